/* rtl/ssbf_pkg.sv */
// Shared types, register indexes and Thumb decode constants for the stack-scan backtrace filter.
package ssbf_pkg;

    localparam int MAX_DEPTH_DEFAULT   = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 40;

    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_BASE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_LENGTH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_LIMIT = 2'd2;

    localparam logic [4:0] DEPTH_LIMIT_RESET = 5'd16;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_WORD   = 1'b1;
    localparam logic RES_ENTRY   = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    localparam logic [15:0] BL_MASK   = 16'hF800;
    localparam logic [15:0] BL_SUFFIX = 16'hF800;
    localparam logic [15:0] BL_PREFIX = 16'hF000;
    localparam logic [15:0] BX_MASK   = 16'hFF00;
    localparam logic [15:0] BX_CODE   = 16'h4700;

    typedef struct packed {
        logic        kind;
        logic [31:0] addr;
        logic [4:0]  idx;
        logic        last;
    } result_t;

    // One queued job: up to two results caused by one input word.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } entry_t;

    // BL immediate pair, or BX/BLX register form in the second halfword.
    function automatic logic is_call_site(input logic [15:0] h1, input logic [15:0] h2);
        logic bl;
        logic bx;
        bl = ((h2 & BL_MASK) == BL_SUFFIX) && ((h1 & BL_MASK) == BL_PREFIX);
        bx = (h2 & BX_MASK) == BX_CODE;
        return bl || bx;
    endfunction

endpackage

/* rtl/ssbf_front.sv */
// Front end: configuration registers, walk state and classification of each accepted word.
module ssbf_front #(
    parameter int MAX_DEPTH = ssbf_pkg::MAX_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [ssbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               in_fire,
    input  logic                               in_kind,
    input  logic [31:0]                        in_word,
    input  logic [31:0]                        in_link,
    input  logic                               in_overflowed,
    input  logic [15:0]                        in_first_half,
    input  logic [15:0]                        in_second_half,
    input  logic                               in_final_word,
    output logic                               push,
    output ssbf_pkg::entry_t                   push_entry
);

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int EW = CW + 5;

    logic [31:0]   base_reg;
    logic [31:0]   length_reg;
    logic [32:0]   base4_reg;
    logic [32:0]   top_reg;
    logic [4:0]    limit_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          linked_reg, linked_next;
    logic [31:0]   second_reg, second_next;

    logic [31:0]   link_addr;
    logic [31:0]   word_addr;
    logic [EW-1:0] count_ext;
    logic [EW-1:0] limit_ext;
    logic [EW-1:0] max_ext;
    logic          room;
    logic          link_ok;
    logic          dup;
    logic          word_ok;
    logic [CW-1:0] count_plus;
    logic [CW-1:0] word_count;
    logic [EW-1:0] cur_ext;
    logic [EW-1:0] word_count_ext;
    logic [4:0]    cur_idx;
    logic [4:0]    word_count_idx;

    // Range bounds are kept as 33-bit sums, refreshed whenever base or length is written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            length_reg <= '0;
            base4_reg  <= 33'd4;
            top_reg    <= '0;
            limit_reg  <= ssbf_pkg::DEPTH_LIMIT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ssbf_pkg::CFG_CODE_BASE: begin
                    base_reg  <= cfg_data;
                    base4_reg <= {1'b0, cfg_data} + 33'd4;
                    top_reg   <= {1'b0, cfg_data} + {1'b0, length_reg};
                end
                ssbf_pkg::CFG_CODE_LENGTH: begin
                    length_reg <= cfg_data;
                    top_reg    <= {1'b0, base_reg} + {1'b0, cfg_data};
                end
                ssbf_pkg::CFG_DEPTH_LIMIT: begin
                    limit_reg <= cfg_data[4:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign link_addr  = in_link - 32'd1;
    assign word_addr  = in_word - 32'd1;
    assign count_ext  = {5'b0, count_reg};
    assign limit_ext  = {{CW{1'b0}}, limit_reg};
    assign max_ext    = EW'(MAX_DEPTH);
    assign room       = (count_ext < max_ext) && (count_ext < limit_ext);
    assign count_plus = count_reg + CW'(1);

    // Link: depth one; user must keep MAX_DEPTH >= 2 (unchecked); range or limit refuse it.
    assign link_ok = (link_addr >= base_reg) && ({1'b0, link_addr} <= top_reg) &&
                     (limit_reg > 5'd1);

    assign dup     = (count_reg == CW'(2)) && linked_reg && (word_addr == second_reg);
    assign word_ok = in_word[0] && ({1'b0, word_addr} >= base4_reg) &&
                     ({1'b0, word_addr} <= top_reg) && room &&
                     ssbf_pkg::is_call_site(in_first_half, in_second_half) && !dup;

    assign word_count     = word_ok ? count_plus : count_reg;
    assign cur_ext        = {5'b0, count_reg};
    assign word_count_ext = {5'b0, word_count};
    assign cur_idx        = cur_ext[4:0];
    assign word_count_idx = word_count_ext[4:0];

    always_comb begin
        push        = 1'b0;
        push_entry  = '0;
        count_next  = count_reg;
        linked_next = linked_reg;
        second_next = second_reg;
        if (in_kind == ssbf_pkg::KIND_START) begin
            count_next  = '0;
            linked_next = 1'b0;
            second_next = '0;
            if (!in_overflowed) begin
                push                   = 1'b1;
                push_entry.first.kind  = ssbf_pkg::RES_ENTRY;
                push_entry.first.addr  = in_word;
                push_entry.first.idx   = 5'd0;
                push_entry.first.last  = !link_ok;
                count_next             = CW'(1);
                if (link_ok) begin
                    push_entry.two         = 1'b1;
                    push_entry.second.kind = ssbf_pkg::RES_ENTRY;
                    push_entry.second.addr = link_addr;
                    push_entry.second.idx  = 5'd1;
                    push_entry.second.last = 1'b1;
                    count_next             = CW'(2);
                    linked_next            = 1'b1;
                    second_next            = link_addr;
                end
            end
        end else begin
            count_next = word_count;
            push       = word_ok || in_final_word;
            if (word_ok) begin
                push_entry.first.kind = ssbf_pkg::RES_ENTRY;
                push_entry.first.addr = word_addr;
                push_entry.first.idx  = cur_idx;
                push_entry.first.last = !in_final_word;
                if (in_final_word) begin
                    push_entry.two         = 1'b1;
                    push_entry.second.kind = ssbf_pkg::RES_SUMMARY;
                    push_entry.second.addr = '0;
                    push_entry.second.idx  = word_count_idx;
                    push_entry.second.last = 1'b1;
                end
            end else begin
                push_entry.first.kind = ssbf_pkg::RES_SUMMARY;
                push_entry.first.addr = '0;
                push_entry.first.idx  = word_count_idx;
                push_entry.first.last = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            linked_reg <= 1'b0;
            second_reg <= '0;
        end else if (in_fire) begin
            count_reg  <= count_next;
            linked_reg <= linked_next;
            second_reg <= second_next;
        end
    end

endmodule

/* rtl/ssbf_queue.sv */
// Short job queue between the classifying front end and the result sequencer.
module ssbf_queue #(
    parameter int DEPTH = ssbf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  ssbf_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output ssbf_pkg::entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    ssbf_pkg::entry_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [NW-1:0] fill_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (fill_reg == NW'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + NW'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

endmodule

/* rtl/ssbf_back.sv */
// Back end: splits each queued job into result words and holds them in the output register.
module ssbf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  ssbf_pkg::entry_t  head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output ssbf_pkg::result_t out_result
);

    logic              out_valid_reg;
    ssbf_pkg::result_t out_reg;
    logic              pend_valid_reg;
    ssbf_pkg::result_t pend_reg;
    logic              out_free;

    assign out_free   = !out_valid_reg || out_ready;
    // Take a new job only once the second result of the previous one is out.
    assign pop        = head_valid && out_free && !pend_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (pend_valid_reg) begin
                out_reg        <= pend_reg;
                out_valid_reg  <= 1'b1;
                pend_valid_reg <= 1'b0;
            end else if (head_valid) begin
                out_reg        <= head.first;
                out_valid_reg  <= 1'b1;
                pend_reg       <= head.second;
                pend_valid_reg <= head.two;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/stack_scan_backtrace_filter_core.sv */
// Stack-scan backtrace filter: Thumb call-site checks on a stream of stack words.
// A result word is registered in the job queue, then in the output register.
// Throughput: one input word per cycle while the job queue has room; the output register
// sends one result per cycle when m_tready is high; a job's two results block new pops.
// Reset: synchronous on aresetn low; clears walk state, queue and output valid, and returns
// the code range to zero and the depth limit to sixteen.
module stack_scan_backtrace_filter_core #(
    parameter int MAX_DEPTH   = ssbf_pkg::MAX_DEPTH_DEFAULT,
    parameter int QUEUE_DEPTH = ssbf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ssbf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // word_value[31:0], link_value[63:32], overflowed[64], first_half[80:65],
    // second_half[96:81], zero pad[103:97]
    input  logic [ssbf_pkg::S_TDATA_W-1:0]     s_tdata,
    // kind[0]
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // entry_address[31:0], entry_index[36:32], zero pad[39:37]
    output logic [ssbf_pkg::M_TDATA_W-1:0]     m_tdata,
    // result_kind[0]
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic              in_fire;
    logic              push;
    ssbf_pkg::entry_t  push_entry;
    logic              q_full;
    logic              pop;
    logic              head_valid;
    ssbf_pkg::entry_t  head;
    ssbf_pkg::result_t out_result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && s_tready;

    ssbf_front #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_fire       (in_fire),
        .in_kind       (s_tuser),
        .in_word       (s_tdata[31:0]),
        .in_link       (s_tdata[63:32]),
        .in_overflowed (s_tdata[64]),
        .in_first_half (s_tdata[80:65]),
        .in_second_half(s_tdata[96:81]),
        .in_final_word (s_tlast),
        .push          (push),
        .push_entry    (push_entry)
    );

    ssbf_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire && push),
        .push_entry(push_entry),
        .full      (q_full),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head)
    );

    ssbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_result(out_result)
    );

    assign m_tdata = {3'b0, out_result.idx, out_result.addr};
    assign m_tuser = out_result.kind;
    assign m_tlast = out_result.last;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ssbf_pkg::RES_SUMMARY) |-> (m_tlast && m_tdata[31:0] == 32'd0))
        else $error("depth summary not closing its run or carrying an address");

    a_entry_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ssbf_pkg::RES_ENTRY) |->
        ((MAX_DEPTH > 31) || (m_tdata[36:32] < 5'(MAX_DEPTH))))
        else $error("entry index beyond the depth bound");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_full && !pop) |=> !s_tready)
        else $error("input ready while the job queue is still full");

endmodule
